// ===== design/bmg_pkg.sv =====
`default_nettype none

package bmg_pkg;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 10;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // position info that travels with a pixel beat
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } t_pos_info;

endpackage

`default_nettype wire

// ===== design/binary_morph_gradient_3x3_core.sv =====
// the result of a window passes the window stage register, then the result register
// throughput: one pixel per cycle while the input is not stalled; the line store is one ram with a registered read
// the input stalls only while the result register is full and the output is stalled
// reset clears the counters, the window columns and sets the size to 640 x 480
// the line store is not cleared; it is refilled before its data reaches an emitted result
`default_nettype none

module binary_morph_gradient_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [0:0]                     i_cfg_index,
    input  wire logic [bmg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_pix_valid,
    output logic                                o_pix_stall,
    input  wire logic                           i_pixel_bit,
    output logic                                o_res_valid,
    input  wire logic                           i_res_stall,
    output logic                                o_edge_bit,
    output logic      [bmg_pkg::OUT_ROW_W-1:0]  o_out_row,
    output logic      [bmg_pkg::OUT_COL_W-1:0]  o_out_col,
    output logic                                o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                 accept;
    logic                 out_ready;
    logic                 a_adv;
    logic [CW-1:0]        col_addr;
    bmg_pkg::t_pos_info   pos_info;
    logic [1:0]           line_rdata;
    logic                 mixed;

    logic                 r_a_valid;
    logic                 r_a_pix;
    logic [CW-1:0]        r_a_addr;
    bmg_pkg::t_pos_info   r_a_info;

    logic                              r_out_valid;
    logic                              r_out_edge;
    logic [bmg_pkg::OUT_ROW_W-1:0]     r_out_row;
    logic [bmg_pkg::OUT_COL_W-1:0]     r_out_col;
    logic                              r_out_last;

    assign out_ready   = !r_out_valid || !i_res_stall;
    assign a_adv       = r_a_valid && out_ready;
    assign o_pix_stall = r_a_valid && !out_ready;
    assign accept      = i_pix_valid && !o_pix_stall;

    bmg_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_col_addr  (col_addr),
        .o_info      (pos_info)
    );

    // bit 0: two rows up, bit 1: one row up
    bmg_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (a_adv),
        .i_waddr (r_a_addr),
        .i_wdata ({r_a_pix, line_rdata[1]}),
        .i_re    (accept),
        .i_raddr (col_addr),
        .o_rdata (line_rdata)
    );

    bmg_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (a_adv),
        .i_top     (line_rdata[0]),
        .i_mid     (line_rdata[1]),
        .i_pix     (r_a_pix),
        .o_mixed   (mixed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix  <= i_pixel_bit;
            r_a_addr <= col_addr;
            r_a_info <= pos_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= a_adv && r_a_info.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out_edge <= mixed;
            r_out_row  <= r_a_info.row;
            r_out_col  <= r_a_info.col;
            r_out_last <= r_a_info.last;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_edge_bit   = r_out_edge;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_last = r_out_last;

    // a held window beat stays put while the result register is blocked
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_out_valid && i_res_stall |=> r_a_valid)
        else $error("window stage dropped a beat while output stalled");

    // an accepted pixel beat always lands in the window stage
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !o_pix_stall |=> r_a_valid)
        else $error("accepted pixel beat not captured");

    // input is only stalled by a full window stage
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> !o_pix_stall)
        else $error("input stalled with empty window stage");

endmodule

`default_nettype wire

// ===== design/bmg_ram.sv =====
`default_nettype none

module bmg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/bmg_ctrl.sv =====
`default_nettype none

module bmg_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [0:0]                     i_cfg_index,
    input  wire logic [bmg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_advance,
    output logic      [CW-1:0]                  o_col_addr,
    output bmg_pkg::t_pos_info                  o_info
);

    localparam int WW = (CW + 1 > bmg_pkg::WIDTH_REG_W) ? CW + 1 : bmg_pkg::WIDTH_REG_W;
    localparam int HW = (RW + 1 > bmg_pkg::HEIGHT_REG_W) ? RW + 1 : bmg_pkg::HEIGHT_REG_W;

    logic [bmg_pkg::WIDTH_REG_W-1:0]  r_image_width;
    logic [bmg_pkg::HEIGHT_REG_W-1:0] r_image_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [31:0]   row_m1;
    logic [31:0]   col_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bmg_pkg::WIDTH_RESET;
            r_image_height <= bmg_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (bmg_pkg::t_cfg_index'(i_cfg_index))
                bmg_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[bmg_pkg::WIDTH_REG_W-1:0];
                end
                bmg_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[bmg_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp the programmed size to 3..max
    always_comb begin
        if (r_image_width < 11'd3) begin
            w_eff = WW'(3);
        end else if (WW'(r_image_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height < 13'd3) begin
            h_eff = HW'(3);
        end else if (HW'(r_image_height) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_image_height);
        end
    end

    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = HW'(r_row) + HW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = row_inc[RW-1:0];
            end
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign row_m1 = 32'(r_row) - 32'd1;
    assign col_m1 = 32'(r_col) - 32'd1;

    always_comb begin
        o_info.emit = (32'(r_row) >= 32'd2) && (32'(r_col) >= 32'd2);
        o_info.last = (HW'(r_row) == h_eff - HW'(1)) && (WW'(r_col) == w_eff - WW'(1));
        o_info.row  = row_m1[bmg_pkg::OUT_ROW_W-1:0];
        o_info.col  = col_m1[bmg_pkg::OUT_COL_W-1:0];
    end

    assign o_col_addr = r_col;

endmodule

`default_nettype wire

// ===== design/bmg_window.sv =====
`default_nettype none

module bmg_window (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  wire logic i_top,
    input  wire logic i_mid,
    input  wire logic i_pix,
    output logic      o_mixed
);

    logic [5:0] r_win_cols;
    logic [8:0] win;

    // oldest column in the low bits, newest column on top
    assign win     = {i_pix, i_mid, i_top, r_win_cols};
    assign o_mixed = (win != 9'h000) && (win != 9'h1FF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cols <= '0;
        end else if (i_advance) begin
            r_win_cols <= win[8:3];
        end
    end

endmodule

`default_nettype wire
